// ===== sv/set_assoc_lru_cache_model_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the set-associative LRU cache model.
// Each macro checks one implication on the clk edge, ignored while in reset.
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_LRU_CACHE_MODEL_ASSERT_SVH
`define SET_ASSOC_LRU_CACHE_MODEL_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SACL_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SACL_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/sacl_pkg.sv =====
// ----------------------------------------------------------------------------
// sacl_pkg
// Shared types and constants of the set-associative LRU cache model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sacl_pkg;

    // Configuration register widths and indexes.
    localparam int SIB_W      = 3;
    localparam int WAYS_W     = 4;
    localparam int BOB_W      = 6;
    localparam int CFG_DATA_W = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int SB_W       = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_SET_INDEX_BITS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_OFFSET_BITS = 2'd2;

    // LRU rank width and width of the count fields on the ports.
    localparam int RANK_W      = 3;
    localparam int OUT_COUNT_W = 32;

    typedef enum logic [2:0] {
        OUT_HIT            = 3'd0,
        OUT_MISS           = 3'd1,
        OUT_MISS_HIT       = 3'd2,
        OUT_MISS_EVICT_HIT = 3'd3,
        OUT_MISS_EVICT     = 3'd4
    } outcome_t;

    // Controller to datapath.
    typedef struct packed {
        logic capture;
        logic commit;
    } ctrl_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== sv/sacl_ctrl.sv =====
// ----------------------------------------------------------------------------
// sacl_ctrl
// Controller: takes an item, issues the set read, then commits the update
// once the output register can take the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "set_assoc_lru_cache_model_assert.svh"

module sacl_ctrl
    import sacl_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire dp_status_t status,
    output ctrl_cmd_t       cmd
);

    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_LOOKUP = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next  = state_reg;
        cmd.capture = 1'b0;
        cmd.commit  = 1'b0;
        in_ready    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                // Hold the looked-up set until the output register is free.
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `SACL_ASSERT_NEXT(a_accept_to_lookup, state_reg == ST_IDLE && in_valid, state_reg == ST_LOOKUP, "accepted item did not start a lookup")
    `SACL_ASSERT_NEXT(a_lookup_holds, state_reg == ST_LOOKUP && !status.out_free, state_reg == ST_LOOKUP, "lookup left while output register was full")
    `SACL_ASSERT_SAME(a_commit_free, cmd.commit, status.out_free && !cmd.capture, "commit issued without a free output register")

endmodule

`default_nettype wire

// ===== sv/sacl_dp.sv =====
// ----------------------------------------------------------------------------
// sacl_dp
// Datapath: configuration registers, set memory, tag compare, LRU update,
// saturating counters and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "set_assoc_lru_cache_model_assert.svh"

module sacl_dp
    import sacl_pkg::*;
#(
    parameter int MAX_SET_BITS = 6,
    parameter int MAX_WAYS     = 8,
    parameter int ADDR_BITS    = 64,
    parameter int COUNT_BITS   = 32
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_write,
    input  wire logic [CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                    command,
    input  wire logic [63:0]             address,
    input  wire logic                    out_ready,
    input  wire ctrl_cmd_t               cmd,
    output dp_status_t                   status,
    output logic                         out_valid,
    output logic [2:0]                   outcome,
    output logic [OUT_COUNT_W-1:0]       hits_total,
    output logic [OUT_COUNT_W-1:0]       misses_total,
    output logic [OUT_COUNT_W-1:0]       evictions_total
);

    localparam int SET_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int NUM_SETS = 1 << MAX_SET_BITS;
    localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

    typedef struct packed {
        logic [MAX_WAYS-1:0]                 valid;
        logic [MAX_WAYS-1:0][ADDR_BITS-1:0]  tag;
        logic [MAX_WAYS-1:0][RANK_W-1:0]     rank;
    } row_t;

    // Configuration.
    logic [SIB_W-1:0]  sib_reg;
    logic [WAYS_W-1:0] ways_reg;
    logic [BOB_W-1:0]  bob_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sib_reg  <= '0;
            ways_reg <= WAYS_W'(1);
            bob_reg  <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_SET_INDEX_BITS:    sib_reg  <= cfg_data[SIB_W-1:0];
                CFG_WAYS_IN_USE:       ways_reg <= cfg_data[WAYS_W-1:0];
                CFG_BLOCK_OFFSET_BITS: bob_reg  <= cfg_data[BOB_W-1:0];
                default:               ;
            endcase
        end
    end

    // Effective geometry after clamping.
    logic [SIB_W-1:0]  s_eff;
    logic [WAYS_W-1:0] ways_eff;
    logic [SB_W-1:0]   sb;

    always_comb
    begin
        s_eff = sib_reg;
        if (int'(sib_reg) > MAX_SET_BITS)
        begin
            s_eff = SIB_W'(MAX_SET_BITS);
        end
        ways_eff = ways_reg;
        if (ways_reg == '0)
        begin
            ways_eff = WAYS_W'(1);
        end
        else if (int'(ways_reg) > MAX_WAYS)
        begin
            ways_eff = WAYS_W'(MAX_WAYS);
        end
        sb = SB_W'(s_eff) + SB_W'(bob_reg);
    end

    // Address split of the incoming item. Shifts past the width give zero.
    logic [ADDR_BITS-1:0] addr_m;
    logic [ADDR_BITS-1:0] addr_sh;
    logic [SET_W-1:0]     set_in;
    logic [ADDR_BITS-1:0] tag_in;

    always_comb
    begin
        addr_m  = address[ADDR_BITS-1:0];
        addr_sh = addr_m >> bob_reg;
        set_in  = addr_sh[SET_W-1:0] & ~({SET_W{1'b1}} << s_eff);
        tag_in  = addr_m >> sb;
    end

    // Set memory, one row per set; a row never written reads as all zero.
    row_t                mem [NUM_SETS];
    logic [NUM_SETS-1:0] live_reg;
    row_t                row_q;
    logic                live_q;
    logic [SET_W-1:0]    set_q;
    logic [ADDR_BITS-1:0] tag_q;
    logic                modify_q;
    row_t                row_new;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            row_q    <= mem[set_in[MAX_SET_BITS > 0 ? SET_W-1 : 0:0]];
            live_q   <= live_reg[set_in[MAX_SET_BITS > 0 ? SET_W-1 : 0:0]];
            set_q    <= set_in;
            tag_q    <= tag_in;
            modify_q <= command;
        end
        if (cmd.commit)
        begin
            mem[set_q] <= row_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg <= '0;
        end
        else if (cmd.commit)
        begin
            live_reg[set_q] <= 1'b1;
        end
    end

    // Lookup and LRU update.
    row_t             row_cur;
    logic             hit;
    logic             has_inv;
    logic [WAY_W-1:0] hit_way;
    logic [WAY_W-1:0] inv_way;
    logic [WAY_W-1:0] vic_way;
    logic [WAY_W-1:0] sel_way;
    logic [RANK_W-1:0] own;
    outcome_t         outcome_c;

    always_comb
    begin
        row_cur = live_q ? row_q : '0;
        hit     = 1'b0;
        has_inv = 1'b0;
        hit_way = '0;
        inv_way = '0;
        vic_way = '0;
        // Scan downward so the lowest matching way wins.
        for (int i = MAX_WAYS - 1; i >= 0; i--)
        begin
            if (i < int'(ways_eff))
            begin
                if (row_cur.valid[i] && row_cur.tag[i] == tag_q)
                begin
                    hit     = 1'b1;
                    hit_way = WAY_W'(i);
                end
                if (!row_cur.valid[i])
                begin
                    has_inv = 1'b1;
                    inv_way = WAY_W'(i);
                end
            end
        end
        // First way with the lowest rank.
        for (int i = 1; i < MAX_WAYS; i++)
        begin
            if (i < int'(ways_eff) && row_cur.rank[i] < row_cur.rank[vic_way])
            begin
                vic_way = WAY_W'(i);
            end
        end

        if (hit)
        begin
            sel_way   = hit_way;
            outcome_c = OUT_HIT;
        end
        else if (has_inv)
        begin
            sel_way   = inv_way;
            outcome_c = modify_q ? OUT_MISS_HIT : OUT_MISS;
        end
        else
        begin
            sel_way   = vic_way;
            outcome_c = modify_q ? OUT_MISS_EVICT_HIT : OUT_MISS_EVICT;
        end

        own     = row_cur.rank[sel_way];
        row_new = row_cur;
        for (int i = 0; i < MAX_WAYS; i++)
        begin
            if (i < int'(ways_eff) && row_cur.valid[i] && row_cur.rank[i] > own)
            begin
                row_new.rank[i] = row_cur.rank[i] - RANK_W'(1);
            end
        end
        row_new.rank[sel_way]  = RANK_W'(ways_eff - WAYS_W'(1));
        row_new.valid[sel_way] = 1'b1;
        if (!hit)
        begin
            row_new.tag[sel_way] = tag_q;
        end
    end

    // Saturating counters.
    logic [COUNT_BITS-1:0] hit_cnt_reg;
    logic [COUNT_BITS-1:0] miss_cnt_reg;
    logic [COUNT_BITS-1:0] evict_cnt_reg;
    logic [COUNT_BITS-1:0] hit_cnt_next;
    logic [COUNT_BITS-1:0] miss_cnt_next;
    logic [COUNT_BITS-1:0] evict_cnt_next;
    logic [1:0]            hit_inc;
    logic [COUNT_BITS:0]   hit_sum;
    logic [COUNT_BITS:0]   miss_sum;
    logic [COUNT_BITS:0]   evict_sum;

    localparam logic [COUNT_BITS:0] COUNT_MAX = {1'b0, {COUNT_BITS{1'b1}}};

    always_comb
    begin
        // A modify always adds one hit for its store.
        hit_inc   = {1'b0, hit} + {1'b0, modify_q};
        hit_sum   = {1'b0, hit_cnt_reg} + (COUNT_BITS + 1)'(hit_inc);
        miss_sum  = {1'b0, miss_cnt_reg} + (COUNT_BITS + 1)'(!hit);
        evict_sum = {1'b0, evict_cnt_reg} + (COUNT_BITS + 1)'(!hit && !has_inv);
        hit_cnt_next   = (hit_sum > COUNT_MAX) ? '1 : hit_sum[COUNT_BITS-1:0];
        miss_cnt_next  = (miss_sum > COUNT_MAX) ? '1 : miss_sum[COUNT_BITS-1:0];
        evict_cnt_next = (evict_sum > COUNT_MAX) ? '1 : evict_sum[COUNT_BITS-1:0];
    end

    logic out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
            evict_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.commit)
            begin
                hit_cnt_reg   <= hit_cnt_next;
                miss_cnt_reg  <= miss_cnt_next;
                evict_cnt_reg <= evict_cnt_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    logic [2:0] outcome_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            outcome_reg <= outcome_c;
        end
    end

    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign outcome         = outcome_reg;
    assign hits_total      = OUT_COUNT_W'(hit_cnt_reg);
    assign misses_total    = OUT_COUNT_W'(miss_cnt_reg);
    assign evictions_total = OUT_COUNT_W'(evict_cnt_reg);

    `SACL_ASSERT_NEXT(a_commit_shows, cmd.commit, out_valid_reg, "committed item not shown at the output")
    `SACL_ASSERT_NEXT(a_set_live, cmd.commit, live_reg[$past(set_q)], "written set not marked live")
    `SACL_ASSERT_NEXT(a_miss_count, cmd.commit && !hit && miss_cnt_reg != '1, miss_cnt_reg != $past(miss_cnt_reg), "miss not counted")

endmodule

`default_nettype wire

// ===== sv/set_assoc_lru_cache_model.sv =====
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_model
// Set-associative cache model with LRU replacement and saturating hit, miss
// and eviction counts; one result item per access item.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_ready   command, address
//   out      output     out_valid / out_ready outcome, hits_total,
//                                             misses_total, evictions_total
//   cfg      input      cfg_write             cfg_index, cfg_data
//
// An item first reads its set row from the set memory, then compares all
// ways, updates the ranks and writes the row back.
// The next item is taken in the cycle after the write-back.
// A result waiting in the output register stalls only the write-back step.
// Reset clears counters, output and live flags; unwritten sets read as empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module set_assoc_lru_cache_model
    import sacl_pkg::*;
#(
    parameter int MAX_SET_BITS = 6,
    parameter int MAX_WAYS     = 8,
    parameter int ADDR_BITS    = 64,
    parameter int COUNT_BITS   = 32
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_write,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic                   command,
    input  wire logic [63:0]            address,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [2:0]                  outcome,
    output logic [OUT_COUNT_W-1:0]      hits_total,
    output logic [OUT_COUNT_W-1:0]      misses_total,
    output logic [OUT_COUNT_W-1:0]      evictions_total
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    sacl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    sacl_dp #(
        .MAX_SET_BITS (MAX_SET_BITS),
        .MAX_WAYS     (MAX_WAYS),
        .ADDR_BITS    (ADDR_BITS),
        .COUNT_BITS   (COUNT_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .command         (command),
        .address         (address),
        .out_ready       (out_ready),
        .cmd             (cmd),
        .status          (status),
        .out_valid       (out_valid),
        .outcome         (outcome),
        .hits_total      (hits_total),
        .misses_total    (misses_total),
        .evictions_total (evictions_total)
    );

endmodule

`default_nettype wire
